>>> design/swpd_pkg.sv
// ----------------------------------------------------------------------------
// swpd_pkg
// shared widths, status codes, register indexes and frame layout constants
// for the sync word packet deframer
// ----------------------------------------------------------------------------
package swpd_pkg;

	localparam int ByteW    = 8;
	localparam int OffW     = 16;
	localparam int StatusW  = 3;
	localparam int LenW     = 16;
	localparam int WordW    = 32;
	localparam int TotalW   = 17;
	localparam int CfgDataW = 32;
	localparam int CfgIdxW  = 2;

	localparam int OffsetWidthDefault = 16;

	typedef logic [StatusW-1:0] status_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam status_t ST_DISCARD    = 3'd0;
	localparam status_t ST_BYTE       = 3'd1;
	localparam status_t ST_DONE       = 3'd2;
	localparam status_t ST_TAIL_ERR   = 3'd3;
	localparam status_t ST_TOO_LONG   = 3'd4;
	localparam status_t ST_VERIFY_ERR = 3'd5;

	localparam cfg_idx_t REG_HEAD_BYTE     = 2'd0;
	localparam cfg_idx_t REG_TAIL_BYTE     = 2'd1;
	localparam cfg_idx_t REG_VERIFY_WORD   = 2'd2;
	localparam cfg_idx_t REG_MAX_FRAME_LEN = 2'd3;

	localparam logic [LenW-1:0] MaxFrameLenReset = 16'd1024;

	localparam logic [OffW-1:0] VerifyLastPos = 16'd4;
	localparam logic [OffW-1:0] SeqPos        = 16'd5;
	localparam logic [OffW-1:0] CmdPos        = 16'd6;
	localparam logic [OffW-1:0] LenFirstPos   = 16'd7;
	localparam logic [OffW-1:0] LenLastPos    = 16'd10;
	localparam logic [OffW-1:0] HeaderBytes   = 16'd11;
	localparam logic [TotalW-1:0] FrameOverhead = 17'd12;

endpackage

>>> design/swpd_if.sv
// ----------------------------------------------------------------------------
// swpd channel interfaces
// valid/ready channels for received bytes and for per-byte results
// ----------------------------------------------------------------------------
interface swpd_rx_if;
	logic                      valid;
	logic                      ready;
	logic [swpd_pkg::ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swpd_res_if;
	logic                        valid;
	logic                        ready;
	logic [swpd_pkg::ByteW-1:0]  data_byte;
	logic [swpd_pkg::OffW-1:0]   byte_offset;
	swpd_pkg::status_t           status;
	logic [swpd_pkg::ByteW-1:0]  seq_num;
	logic [swpd_pkg::ByteW-1:0]  command;
	logic [swpd_pkg::LenW-1:0]   payload_len;

	modport source (output valid, output data_byte, output byte_offset, output status,
		output seq_num, output command, output payload_len, input ready);
	modport sink   (input valid, input data_byte, input byte_offset, input status,
		input seq_num, input command, input payload_len, output ready);
endinterface

>>> design/sync_word_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_top
// byte-serial deframer: head hunt, verify word, seq/cmd, 32-bit le length,
// payload pass-through and tail check, one result beat per byte
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  rx        in   valid/ready    rx_byte
//  result    out  valid/ready    data_byte, byte_offset, status, seq_num,
//                                command, payload_len
//  wr        in   wr_en only     wr_index, wr_data
//
//  one byte per cycle while the result side is not stalled; an accepted byte
//  passes through the input register, then the result register
//  the frame state advances as a byte moves into the result register
//  reset clears the frame state and loads register defaults
//  a stalled result holds while the input register still takes one byte
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_top #(
	parameter int OFFSET_WIDTH = swpd_pkg::OffsetWidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	swpd_rx_if.sink                       rx,
	swpd_res_if.source                    result,
	input  logic                          wr_en,
	input  swpd_pkg::cfg_idx_t            wr_index,
	input  logic [swpd_pkg::CfgDataW-1:0] wr_data
);

	localparam int OffKeep = (OFFSET_WIDTH < swpd_pkg::OffW) ? OFFSET_WIDTH : swpd_pkg::OffW;
	localparam logic [swpd_pkg::OffW-1:0] OffMask =
		{swpd_pkg::OffW{1'b1}} >> (swpd_pkg::OffW - OffKeep);

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_VERIFY = 2'd1;
	localparam logic [1:0] PH_HEADER = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	// configuration
	logic [swpd_pkg::ByteW-1:0] head_q;
	logic [swpd_pkg::ByteW-1:0] tail_q;
	logic [swpd_pkg::WordW-1:0] verify_q;
	logic [swpd_pkg::LenW-1:0]  max_len_q;

	// frame state
	logic [1:0]                  phase_q, phase_d;
	logic [swpd_pkg::OffW-1:0]   pos_q, pos_d;
	logic [swpd_pkg::ByteW-1:0]  seq_q, seq_d;
	logic [swpd_pkg::ByteW-1:0]  cmd_q, cmd_d;
	logic [swpd_pkg::WordW-1:0]  acc_q, acc_d;
	logic [swpd_pkg::TotalW-1:0] total_q, total_d;

	// pipeline
	logic                        v_s1;
	logic [swpd_pkg::ByteW-1:0]  byte_s1;
	logic                        v_s2;
	logic [swpd_pkg::ByteW-1:0]  data_s2;
	logic [swpd_pkg::OffW-1:0]   off_s2;
	swpd_pkg::status_t           status_s2;
	logic [swpd_pkg::ByteW-1:0]  seq_s2;
	logic [swpd_pkg::ByteW-1:0]  cmd_s2;
	logic [swpd_pkg::LenW-1:0]   plen_s2;

	logic                        advance;

	// per-byte decisions
	swpd_pkg::status_t           st_c;
	logic [swpd_pkg::OffW-1:0]   off_c;
	logic [swpd_pkg::ByteW-1:0]  seq_c;
	logic [swpd_pkg::ByteW-1:0]  cmd_c;
	logic [swpd_pkg::LenW-1:0]   plen_c;
	logic [1:0]                  vidx;
	logic [1:0]                  lidx;
	logic [swpd_pkg::ByteW-1:0]  want;
	logic [swpd_pkg::WordW-1:0]  acc_new;
	logic [swpd_pkg::WordW:0]    total_c;
	logic                        too_long;
	logic [swpd_pkg::TotalW-1:0] next_pos_w;
	logic [swpd_pkg::TotalW-1:0] plen_w;

	assign advance  = v_s1 && (!v_s2 || result.ready);
	assign rx.ready = !v_s1 || advance;

	assign vidx       = pos_q[1:0] - 2'd1;
	assign lidx       = pos_q[1:0] - 2'd3;
	assign want       = verify_q[{vidx, 3'b000} +: 8];
	assign next_pos_w = {1'b0, pos_q} + 17'd1;
	assign plen_w     = total_q - swpd_pkg::FrameOverhead;

	always_comb begin
		acc_new = acc_q;
		if (pos_q >= swpd_pkg::LenFirstPos && pos_q <= swpd_pkg::LenLastPos) begin
			acc_new[{lidx, 3'b000} +: 8] = acc_q[{lidx, 3'b000} +: 8] | byte_s1;
		end
	end

	assign total_c  = {1'b0, acc_new} + {16'd0, swpd_pkg::FrameOverhead};
	assign too_long = total_c > {17'd0, max_len_q};

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		seq_d   = seq_q;
		cmd_d   = cmd_q;
		acc_d   = acc_q;
		total_d = total_q;
		st_c    = swpd_pkg::ST_DISCARD;
		off_c   = '0;
		seq_c   = '0;
		cmd_c   = '0;
		plen_c  = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == head_q) begin
					st_c    = swpd_pkg::ST_BYTE;
					phase_d = PH_VERIFY;
					pos_d   = 16'd1;
					acc_d   = '0;
					total_d = '0;
				end
			end
			PH_VERIFY: begin
				if (byte_s1 == want) begin
					st_c  = swpd_pkg::ST_BYTE;
					off_c = pos_q;
					pos_d = next_pos_w[swpd_pkg::OffW-1:0];
					if (pos_q >= swpd_pkg::VerifyLastPos) begin
						phase_d = PH_HEADER;
					end
				end else if (byte_s1 == head_q) begin
					st_c    = swpd_pkg::ST_BYTE;
					pos_d   = 16'd1;
					acc_d   = '0;
					total_d = '0;
				end else begin
					st_c    = swpd_pkg::ST_VERIFY_ERR;
					off_c   = pos_q;
					phase_d = PH_HUNT;
					pos_d   = '0;
					acc_d   = '0;
					total_d = '0;
				end
			end
			PH_HEADER: begin
				st_c  = swpd_pkg::ST_BYTE;
				off_c = pos_q;
				pos_d = next_pos_w[swpd_pkg::OffW-1:0];
				acc_d = acc_new;
				if (pos_q == swpd_pkg::SeqPos) begin
					seq_d = byte_s1;
				end
				if (pos_q == swpd_pkg::CmdPos) begin
					cmd_d = byte_s1;
				end
				if (pos_q >= swpd_pkg::LenLastPos) begin
					if (too_long) begin
						st_c    = swpd_pkg::ST_TOO_LONG;
						phase_d = PH_HUNT;
						pos_d   = '0;
						acc_d   = '0;
						total_d = '0;
					end else begin
						phase_d = PH_BODY;
						pos_d   = swpd_pkg::HeaderBytes;
						total_d = total_c[swpd_pkg::TotalW-1:0];
					end
				end
			end
			PH_BODY: begin
				off_c = pos_q;
				if (next_pos_w >= total_q) begin
					if (byte_s1 == tail_q) begin
						st_c   = swpd_pkg::ST_DONE;
						seq_c  = seq_q;
						cmd_c  = cmd_q;
						plen_c = plen_w[swpd_pkg::LenW-1:0];
					end else begin
						st_c = swpd_pkg::ST_TAIL_ERR;
					end
					phase_d = PH_HUNT;
					pos_d   = '0;
					acc_d   = '0;
					total_d = '0;
				end else begin
					st_c  = swpd_pkg::ST_BYTE;
					pos_d = next_pos_w[swpd_pkg::OffW-1:0];
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			verify_q  <= '0;
			max_len_q <= swpd_pkg::MaxFrameLenReset;
		end else if (wr_en) begin
			case (wr_index)
				swpd_pkg::REG_HEAD_BYTE:     head_q    <= wr_data[swpd_pkg::ByteW-1:0];
				swpd_pkg::REG_TAIL_BYTE:     tail_q    <= wr_data[swpd_pkg::ByteW-1:0];
				swpd_pkg::REG_VERIFY_WORD:   verify_q  <= wr_data[swpd_pkg::WordW-1:0];
				swpd_pkg::REG_MAX_FRAME_LEN: max_len_q <= wr_data[swpd_pkg::LenW-1:0];
				default: begin
				end
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			seq_q   <= '0;
			cmd_q   <= '0;
			acc_q   <= '0;
			total_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			seq_q   <= seq_d;
			cmd_q   <= cmd_d;
			acc_q   <= acc_d;
			total_q <= total_d;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				v_s1 <= rx.valid;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
		if (advance) begin
			data_s2   <= byte_s1;
			off_s2    <= off_c & OffMask;
			status_s2 <= st_c;
			seq_s2    <= seq_c;
			cmd_s2    <= cmd_c;
			plen_s2   <= plen_c;
		end
	end

	assign result.valid       = v_s2;
	assign result.data_byte   = data_s2;
	assign result.byte_offset = off_s2;
	assign result.status      = status_s2;
	assign result.seq_num     = seq_s2;
	assign result.command     = cmd_s2;
	assign result.payload_len = plen_s2;

endmodule

>>> design/swpd_checker.sv
// ----------------------------------------------------------------------------
// swpd_checker
// port-level checks on the deframer result channel, bound to the top level
// ----------------------------------------------------------------------------
module swpd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [swpd_pkg::ByteW-1:0]   res_data,
	input logic [swpd_pkg::OffW-1:0]    res_offset,
	input swpd_pkg::status_t            res_status,
	input logic [swpd_pkg::ByteW-1:0]   res_seq,
	input logic [swpd_pkg::ByteW-1:0]   res_cmd,
	input logic [swpd_pkg::LenW-1:0]    res_plen
);

	// header fields only on a completed frame
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != swpd_pkg::ST_DONE
		|-> res_seq == '0 && res_cmd == '0 && res_plen == '0)
		else $error("header fields set on a beat that is not frame complete");

	// discarded bytes sit outside any frame
	a_discard_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == swpd_pkg::ST_DISCARD |-> res_offset == '0)
		else $error("discarded beat with nonzero offset");

	// length check fires on the last length byte only
	a_too_long_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == swpd_pkg::ST_TOO_LONG |-> res_offset == 16'd10)
		else $error("length error at wrong offset");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data) && $stable(res_offset)
		&& $stable(res_status) && $stable(res_plen))
		else $error("result beat changed while stalled");

endmodule

bind sync_word_packet_deframer_top swpd_checker u_swpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_data   (result.data_byte),
	.res_offset (result.byte_offset),
	.res_status (result.status),
	.res_seq    (result.seq_num),
	.res_cmd    (result.command),
	.res_plen   (result.payload_len)
);

>>> tb/sync_word_packet_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_top_tb
// drives received bytes into the deframer and tracks head hunt, verify word,
// header, length limit and tail check in a local shadow of the frame state;
// every result beat is compared field by field with the oldest pending
// prediction, with random gaps on the byte side and random stalls on the
// result side
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_top_tb;
	import swpd_pkg::*;

	localparam int QuietLimit = 1000;
	localparam int RandomPhases = 5;
	localparam int BytesPerPhase = 130;
	localparam int ShortBodyMax = 40;
	localparam int LargestFrame = 140;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_VERIFY,
		PH_HEADER,
		PH_BODY
	} deframe_phase_t;

	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic [OffW-1:0]  byte_offset;
		status_t          status;
		logic [ByteW-1:0] seq_num;
		logic [ByteW-1:0] command;
		logic [LenW-1:0]  payload_len;
	} byte_report_t;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	cfg_idx_t            wr_index;
	logic [CfgDataW-1:0] wr_data;

	swpd_rx_if  rx_ch();
	swpd_res_if res_ch();

	sync_word_packet_deframer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_ch),
		.result   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// shadow of the registers
	logic [ByteW-1:0] head_val;
	logic [ByteW-1:0] tail_val;
	logic [WordW-1:0] verify_val;
	logic [LenW-1:0]  max_len_val;

	// shadow of the frame state
	deframe_phase_t    phase_q;
	logic [OffW-1:0]   pos_q;
	logic [ByteW-1:0]  seq_q;
	logic [ByteW-1:0]  cmd_q;
	logic [WordW-1:0]  len_q;
	logic [TotalW-1:0] total_q;

	byte_report_t pending_reports[$];
	int           err_count = 0;
	int           sent_count = 0;
	int           quiet_cycles = 0;
	bit           idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void enter_hunt();
		phase_q = PH_HUNT;
		pos_q   = '0;
		len_q   = '0;
		total_q = '0;
	endfunction

	function automatic void enter_verify();
		phase_q = PH_VERIFY;
		pos_q   = 16'd1;
		len_q   = '0;
		total_q = '0;
	endfunction

	function automatic byte_report_t deframe_byte(input logic [ByteW-1:0] b);
		byte_report_t      r;
		logic [OffW-1:0]   pos;
		int                vidx;
		logic [WordW:0]    total;
		r = '0;
		r.data_byte = b;
		r.status = ST_DISCARD;
		pos = pos_q;
		case (phase_q)
			PH_HUNT: begin
				if (b == head_val) begin
					r.status = ST_BYTE;
					enter_verify();
				end
			end
			PH_VERIFY: begin
				vidx = (pos >= 16'd1 && pos <= VerifyLastPos) ? int'(pos) - 1 : 0;
				if (b == verify_val[8*vidx +: 8]) begin
					r.status = ST_BYTE;
					r.byte_offset = pos;
					pos_q = pos + 16'd1;
					if (pos_q > VerifyLastPos)
						phase_q = PH_HEADER;
				end else if (b == head_val) begin
					r.status = ST_BYTE;
					enter_verify();
				end else begin
					r.status = ST_VERIFY_ERR;
					r.byte_offset = pos;
					enter_hunt();
				end
			end
			PH_HEADER: begin
				r.status = ST_BYTE;
				r.byte_offset = pos;
				if (pos == SeqPos)
					seq_q = b;
				else if (pos == CmdPos)
					cmd_q = b;
				else if (pos >= LenFirstPos && pos <= LenLastPos)
					len_q = len_q | (32'(b) << (8 * int'(pos - LenFirstPos)));
				pos_q = pos + 16'd1;
				if (pos >= LenLastPos) begin
					// full-width compare, no wrap on huge lengths
					total = {1'b0, len_q} + 33'(FrameOverhead);
					if (total > 33'(max_len_val)) begin
						r.status = ST_TOO_LONG;
						enter_hunt();
					end else begin
						total_q = total[TotalW-1:0];
						pos_q = HeaderBytes;
						phase_q = PH_BODY;
					end
				end
			end
			default: begin
				r.byte_offset = pos;
				if ({1'b0, pos} + 17'd1 >= total_q) begin
					if (b == tail_val) begin
						r.status = ST_DONE;
						r.seq_num = seq_q;
						r.command = cmd_q;
						r.payload_len = LenW'(total_q - FrameOverhead);
					end else begin
						r.status = ST_TAIL_ERR;
					end
					enter_hunt();
				end else begin
					r.status = ST_BYTE;
					pos_q = pos + 16'd1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_byte(input logic [ByteW-1:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		pending_reports.push_back(deframe_byte(b));
		sent_count++;
	endtask

	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_HEAD_BYTE:     head_val = val[ByteW-1:0];
			REG_TAIL_BYTE:     tail_val = val[ByteW-1:0];
			REG_VERIFY_WORD:   verify_val = val;
			REG_MAX_FRAME_LEN: max_len_val = val[LenW-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic [ByteW-1:0] head, input logic [ByteW-1:0] tail,
			input logic [WordW-1:0] verify, input logic [LenW-1:0] len_cap);
		write_reg(REG_HEAD_BYTE, 32'(head));
		write_reg(REG_TAIL_BYTE, 32'(tail));
		write_reg(REG_VERIFY_WORD, verify);
		write_reg(REG_MAX_FRAME_LEN, 32'(len_cap));
	endtask

	function automatic logic [ByteW-1:0] pick_wrong(input logic [ByteW-1:0] want);
		logic [ByteW-1:0] b;
		do b = 8'($urandom); while (b == want || b == head_val);
		return b;
	endfunction

	task automatic send_head_verify(input int n_verify);
		send_byte(head_val);
		for (int i = 0; i < n_verify; i++)
			send_byte(verify_val[8*i +: 8]);
	endtask

	task automatic send_header(input logic [ByteW-1:0] seq, input logic [ByteW-1:0] cmd,
			input logic [WordW-1:0] len);
		send_head_verify(4);
		send_byte(seq);
		send_byte(cmd);
		for (int i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
	endtask

	task automatic send_body(input int n, input bit good_tail);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom));
		send_byte(good_tail ? tail_val : tail_val ^ 8'($urandom_range(1, 255)));
	endtask

	task automatic send_frame(input int n, input bit good_tail);
		send_header(8'($urandom), 8'($urandom), 32'(n));
		send_body(n, good_tail);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endfunction

	task automatic check_report();
		byte_report_t want;
		if (pending_reports.size() == 0) begin
			$error("result beat with nothing pending: data_byte %0h", res_ch.data_byte);
			err_count++;
		end else begin
			want = pending_reports.pop_front();
			check_field("data_byte", 32'(want.data_byte), 32'(res_ch.data_byte));
			check_field("byte_offset", 32'(want.byte_offset), 32'(res_ch.byte_offset));
			check_field("status", 32'(want.status), 32'(res_ch.status));
			check_field("seq_num", 32'(want.seq_num), 32'(res_ch.seq_num));
			check_field("command", 32'(want.command), 32'(res_ch.command));
			check_field("payload_len", 32'(want.payload_len), 32'(res_ch.payload_len));
		end
	endtask

	// result side: random stall before each beat
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			check_report();
		end
	end

	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("sync_word_packet_deframer_top_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// register defaults straight out of reset
	task automatic test_reset_defaults();
		send_byte(8'hFF);
		send_byte(8'h55);
		send_header(8'hFF, 8'h00, 32'd0);
		send_body(0, 1'b1);
		send_header(8'h00, 8'hFF, 32'd3);
		send_body(3, 1'b1);
		drain_results();
	endtask

	// head restart and mismatch at every verify position
	task automatic test_verify_faults();
		set_config(8'hFF, 8'h00, 32'hA5C3_3C5A, 16'd12);
		for (int k = 0; k < 4; k++) begin
			send_head_verify(k);
			send_byte(head_val);
			for (int j = 0; j < k; j++)
				send_byte(verify_val[8*j +: 8]);
			send_byte(pick_wrong(verify_val[8*k +: 8]));
		end
		drain_results();
	endtask

	task automatic test_length_limits();
		send_frame(0, 1'b1);
		send_header(8'h01, 8'h02, 32'd1);
		send_header(8'h03, 8'h04, 32'hFFFF_FFFF);
		send_frame(0, 1'b0);
		drain_results();
		write_reg(REG_MAX_FRAME_LEN, 32'hFFFF);
		send_header(8'h05, 8'h06, 32'd65524);
		send_header(8'h07, 8'h08, 32'h0001_0000);
		drain_results();
	endtask

	// longest frame the length limit lets through, bytes back to back
	task automatic test_largest_frame();
		idle_on = 1'b0;
		write_reg(REG_MAX_FRAME_LEN, 32'(LargestFrame));
		send_frame(LargestFrame - 12, 1'b1);
		drain_results();
		idle_on = 1'b1;
	endtask

	// frame held open while registers change
	task automatic test_config_mid_frame();
		set_config(8'h7E, 8'hE7, 32'h0102_7E03, 16'd64);
		send_header(8'h11, 8'h22, 32'd4);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		drain_results();
		write_reg(REG_TAIL_BYTE, 32'h81);
		send_body(2, 1'b1);
		send_head_verify(2);
		drain_results();
		write_reg(REG_HEAD_BYTE, 32'hC3);
		send_frame(1, 1'b1);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int               kind;
		int               n;
		int               k;
		int               phase_start;
		logic [LenW-1:0]  len_cap;
		logic [WordW-1:0] len;
		for (int ph = 0; ph < RandomPhases; ph++) begin
			case (ph)
				0:       len_cap = 16'd12;
				1:       len_cap = 16'hFFFF;
				2:       len_cap = 16'($urandom_range(12, 40));
				3:       len_cap = 16'($urandom_range(12, 65535));
				default: len_cap = 16'($urandom_range(13, 64));
			endcase
			set_config(8'($urandom), 8'($urandom), $urandom, len_cap);
			idle_on = (ph != 2);
			phase_start = sent_count;
			while (sent_count - phase_start < BytesPerPhase) begin
				kind = $urandom_range(0, 99);
				n = $urandom_range(0, (int'(max_len_val) - 12 < ShortBodyMax) ?
					int'(max_len_val) - 12 : ShortBodyMax);
				if (kind < 60) begin
					send_frame(n, 1'b1);
				end else if (kind < 70) begin
					send_frame(n, 1'b0);
				end else if (kind < 78) begin
					len = ($urandom_range(0, 3) == 0) ? $urandom :
						32'(max_len_val) - 32'd11 + $urandom_range(0, 300);
					send_header(8'($urandom), 8'($urandom), len);
				end else if (kind < 86) begin
					k = $urandom_range(0, 3);
					send_head_verify(k);
					send_byte(pick_wrong(verify_val[8*k +: 8]));
				end else if (kind < 92) begin
					send_head_verify($urandom_range(0, 3));
					send_frame(n, 1'b1);
				end else begin
					repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
				end
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_HEAD_BYTE;
		wr_data <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		idle_on = 1'b1;
		head_val = '0;
		tail_val = '0;
		verify_val = '0;
		max_len_val = MaxFrameLenReset;
		seq_q = '0;
		cmd_q = '0;
		enter_hunt();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_verify_faults();
		test_length_limits();
		test_largest_frame();
		test_config_mid_frame();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("sync_word_packet_deframer_top_tb OK");
		else
			$display("sync_word_packet_deframer_top_tb NOT OK");
		$finish;
	end

endmodule
